### hdl/rcfp_pkg.sv
// rcfp_pkg: shared types and constants for the rc channel frame parser
// no dependencies; imported by rcfp_front, rcfp_back and the top level
package rcfp_pkg;

  // frame layout constants
  localparam logic [7:0]  HDR_FIRST         = 8'h20;
  localparam logic [7:0]  HDR_SECOND        = 8'h40;
  localparam logic [15:0] SUM_SEED          = 16'hFFFF;
  localparam logic [4:0]  LAST_PAYLOAD_CNT  = 5'd30;
  localparam logic [4:0]  FIRST_PAYLOAD_CNT = 5'd3;

  // field widths
  localparam int unsigned CH_IDX_W = 4;
  localparam int unsigned CH_VAL_W = 16;

  // parser phase
  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_HDR0    = 3'd1,
    PH_PAYLOAD = 3'd2,
    PH_SUMLO   = 3'd3,
    PH_SUMHI   = 3'd4
  } phase_e;

  // emitter state
  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_EMIT = 1'b1
  } bk_state_e;

  // channel store write port, front to back
  typedef struct packed {
    logic                en;
    logic                bank;
    logic [CH_IDX_W-1:0] slot;
    logic [CH_VAL_W-1:0] data;
  } store_wr_t;

  // good-frame token
  typedef struct packed {
    logic valid;
    logic bank;
  } tok_t;

endpackage

### hdl/rcfp_front.sv
// rcfp_front: byte parser, checksum tracking and channel store writes
// depends on rcfp_pkg; pushes a bank token for every frame with a good checksum
module rcfp_front
  import rcfp_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = 14
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        rx_valid_i,
  output logic        rx_ready_o,
  input  logic [7:0]  rx_byte_i,
  input  logic [1:0]  bank_busy_i,
  output store_wr_t   wr_o,
  output tok_t        push_o
);

  localparam logic [CH_IDX_W:0] NumCh = (CH_IDX_W+1)'(NUM_CHANNELS);

  phase_e            phase_q, phase_d;
  logic [4:0]        count_q, count_d;
  logic [15:0]       sum_q, sum_d;
  logic [7:0]        sum_lo_q, sum_lo_d;
  logic [7:0]        lo_q, lo_d;
  logic              wr_bank_q, wr_bank_d;

  logic              accept;
  logic [4:0]        count_inc;
  logic [4:0]        slot_full;
  logic [CH_IDX_W-1:0] slot;
  logic [15:0]       sum_sub;
  logic              sum_match;

  // hold off while the bank being filled still waits to be emitted
  assign rx_ready_o = !bank_busy_i[wr_bank_q];
  assign accept     = rx_valid_i && rx_ready_o;

  assign count_inc = count_q + 5'd1;
  assign slot_full = count_inc - FIRST_PAYLOAD_CNT;
  assign slot      = slot_full[4:1];
  assign sum_sub   = sum_q - {8'h00, rx_byte_i};
  assign sum_match = ({rx_byte_i, sum_lo_q} == sum_q);

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (accept) begin
      unique case (phase_q)
        PH_HDR0:    phase_d = (rx_byte_i == HDR_SECOND) ? PH_PAYLOAD : PH_IDLE;
        PH_PAYLOAD: if (count_inc >= LAST_PAYLOAD_CNT) phase_d = PH_SUMLO;
        PH_SUMLO:   phase_d = PH_SUMHI;
        PH_SUMHI:   phase_d = PH_IDLE;
        default:    phase_d = (rx_byte_i == HDR_FIRST) ? PH_HDR0 : PH_IDLE;
      endcase
    end
  end

  // datapath updates, store writes and token push
  always_comb begin
    count_d   = count_q;
    sum_d     = sum_q;
    sum_lo_d  = sum_lo_q;
    lo_d      = lo_q;
    wr_bank_d = wr_bank_q;
    wr_o      = '0;
    push_o    = '0;
    if (accept) begin
      unique case (phase_q)
        PH_HDR0: begin
          if (rx_byte_i == HDR_SECOND) begin
            count_d = 5'd2;
            sum_d   = sum_sub;
          end else begin
            count_d = 5'd0;
          end
        end
        PH_PAYLOAD: begin
          count_d = count_inc;
          sum_d   = sum_sub;
          if (count_inc >= FIRST_PAYLOAD_CNT) begin
            if (count_inc[0]) begin
              lo_d = rx_byte_i;
            end else if ({1'b0, slot} < NumCh) begin
              wr_o.en   = 1'b1;
              wr_o.bank = wr_bank_q;
              wr_o.slot = slot;
              wr_o.data = {rx_byte_i, lo_q};
            end
          end
        end
        PH_SUMLO: begin
          sum_lo_d = rx_byte_i;
        end
        PH_SUMHI: begin
          count_d = 5'd0;
          if (sum_match) begin
            push_o.valid = 1'b1;
            push_o.bank  = wr_bank_q;
            wr_bank_d    = !wr_bank_q;
          end
        end
        default: begin
          if (rx_byte_i == HDR_FIRST) begin
            count_d = 5'd1;
            sum_d   = SUM_SEED - {8'h00, rx_byte_i};
          end
        end
      endcase
    end
  end

  // registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      count_q   <= 5'd0;
      sum_q     <= 16'h0000;
      sum_lo_q  <= 8'h00;
      lo_q      <= 8'h00;
      wr_bank_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      count_q   <= count_d;
      sum_q     <= sum_d;
      sum_lo_q  <= sum_lo_d;
      lo_q      <= lo_d;
      wr_bank_q <= wr_bank_d;
    end
  end

endmodule

### hdl/rcfp_tok_fifo.sv
// rcfp_tok_fifo: two-entry queue of good-frame bank tokens
// depends on nothing beyond its ports; sits between parser and emitter
module rcfp_tok_fifo (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  logic push_data_i,
  input  logic pop_i,
  output logic pop_data_o,
  output logic empty_o,
  output logic full_o
);

  logic [1:0] mem_q;
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;
  logic       do_push, do_pop;

  assign empty_o    = (fill_q == 2'd0);
  assign full_o     = (fill_q == 2'd2);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;

  // pointer and fill updates
  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q;
    if (do_push && !do_pop) begin
      fill_d = fill_q + 2'd1;
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // token storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### hdl/rcfp_back.sv
// rcfp_back: two-bank channel store and the emitter that walks a good frame
// depends on rcfp_pkg; takes bank tokens from rcfp_tok_fifo
module rcfp_back
  import rcfp_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = 14
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  store_wr_t           wr_i,
  input  tok_t                push_i,
  input  logic                fifo_empty_i,
  input  logic                fifo_data_i,
  output logic                fifo_pop_o,
  output logic [1:0]          bank_busy_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [CH_IDX_W-1:0] channel_index_o,
  output logic [CH_VAL_W-1:0] channel_value_o,
  output logic                last_channel_o
);

  localparam int unsigned IdxW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [CH_IDX_W-1:0] LastIdx = CH_IDX_W'(NUM_CHANNELS - 1);

  logic [CH_VAL_W-1:0] store_q [2][NUM_CHANNELS];

  bk_state_e           state_q, state_d;
  logic                bank_q;
  logic [CH_IDX_W-1:0] idx_q;
  logic [1:0]          busy_q, busy_d;
  logic                out_valid_q;
  logic [CH_IDX_W-1:0] out_idx_q;
  logic [CH_VAL_W-1:0] out_val_q;
  logic                out_last_q;

  logic                load;
  logic                is_last;

  assign load    = (state_q == BK_EMIT) && (!out_valid_q || out_ready_i);
  assign is_last = (idx_q == LastIdx);

  // channel store, written by the parser
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      store_q[wr_i.bank][wr_i.slot[IdxW-1:0]] <= wr_i.data;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: if (!fifo_empty_i) state_d = BK_EMIT;
      BK_EMIT: if (load && is_last) state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    fifo_pop_o = (state_q == BK_IDLE) && !fifo_empty_i;
  end

  // bank ownership: set by a good frame, freed once its last channel is read
  always_comb begin
    busy_d = busy_q;
    if (load && is_last) begin
      busy_d[bank_q] = 1'b0;
    end
    if (push_i.valid) begin
      busy_d[push_i.bank] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      bank_q      <= 1'b0;
      idx_q       <= '0;
      busy_q      <= 2'b00;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= busy_d;
      if (fifo_pop_o) begin
        bank_q <= fifo_data_i;
        idx_q  <= '0;
      end else if (load) begin
        idx_q <= idx_q + 1'b1;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // output word register
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_idx_q  <= idx_q;
      out_val_q  <= store_q[bank_q][idx_q[IdxW-1:0]];
      out_last_q <= is_last;
    end
  end

  assign bank_busy_o     = busy_q;
  assign out_valid_o     = out_valid_q;
  assign channel_index_o = out_idx_q;
  assign channel_value_o = out_val_q;
  assign last_channel_o  = out_last_q;

endmodule

### hdl/rc_channel_frame_parser.sv
// channel   | dir | handshake                | word
// rx        | in  | rx_valid_i / rx_ready_o  | rx_byte_i
// channel   | out | out_valid_o / out_ready_i| channel_index_o, channel_value_o, last_channel_o
//
// one received byte is taken per cycle while the bank being filled is free.
// a checksum byte that matches hands the frame's bank to the emitter, which
// sends NUM_CHANNELS words from its output register at one per cycle while out_ready_i is high.
// two channel banks let the next frame fill while the last one drains; the
// input stalls only when both banks still wait to be emitted.
// rst_ni clears parser phase, queue and emitter; channel banks are not reset.
//
// top level: parser front, token queue and emitter back; depends on rcfp_pkg
module rc_channel_frame_parser
  import rcfp_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = 14
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                rx_valid_i,
  output logic                rx_ready_o,
  input  logic [7:0]          rx_byte_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [CH_IDX_W-1:0] channel_index_o,
  output logic [CH_VAL_W-1:0] channel_value_o,
  output logic                last_channel_o
);

  store_wr_t  wr;
  tok_t       push;
  logic [1:0] bank_busy;
  logic       fifo_pop;
  logic       fifo_data;
  logic       fifo_empty;
  logic       fifo_full;

  // parser
  rcfp_front #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_valid_i (rx_valid_i),
    .rx_ready_o (rx_ready_o),
    .rx_byte_i  (rx_byte_i),
    .bank_busy_i(bank_busy),
    .wr_o       (wr),
    .push_o     (push)
  );

  // good-frame queue
  rcfp_tok_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push.valid),
    .push_data_i(push.bank),
    .pop_i      (fifo_pop),
    .pop_data_o (fifo_data),
    .empty_o    (fifo_empty),
    .full_o     (fifo_full)
  );

  // store and emitter
  rcfp_back #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .wr_i           (wr),
    .push_i         (push),
    .fifo_empty_i   (fifo_empty),
    .fifo_data_i    (fifo_data),
    .fifo_pop_o     (fifo_pop),
    .bank_busy_o    (bank_busy),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .channel_index_o(channel_index_o),
    .channel_value_o(channel_value_o),
    .last_channel_o (last_channel_o)
  );

  // token queue never overflows
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.valid |-> !fifo_full)
    else $error("token pushed into a full queue");

  // parser never writes a bank that still waits to be emitted
  a_no_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.en |-> !bank_busy[wr.bank])
    else $error("write into a busy channel bank");

  // last marker only on the final channel
  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_channel_o) |-> (channel_index_o == CH_IDX_W'(NUM_CHANNELS - 1)))
    else $error("last marker on wrong channel index");

  // a word after the last one restarts at channel zero
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_channel_o) ##1 out_valid_o
      |-> (channel_index_o == '0))
    else $error("new frame does not start at channel zero");

endmodule
